// File: src/tcmc_pkg.sv
// ----------------------------------------------------------------------------
// tcmc_pkg
// Shared types and constants for the three-colour minimum-change traceback.
// ----------------------------------------------------------------------------
package tcmc_pkg;

	localparam logic [7:0] SYM_RED   = 8'd82;
	localparam logic [7:0] SYM_GREEN = 8'd71;

	localparam logic [1:0] COL_RED   = 2'd0;
	localparam logic [1:0] COL_GREEN = 2'd1;
	localparam logic [1:0] COL_BLUE  = 2'd2;

	localparam int QDEPTH = 2;

	// classified word passed from front to back
	typedef struct packed {
		logic [1:0] obs;
		logic       drop;
		logic       last;
	} item_t;

	// the two colours other than c: {hi, lo}
	function automatic logic [3:0] others(input logic [1:0] c);
		logic [3:0] r;
		begin
			case (c)
				COL_RED:   r = {COL_BLUE, COL_GREEN};
				COL_GREEN: r = {COL_BLUE, COL_RED};
				default:   r = {COL_GREEN, COL_RED};
			endcase
			return r;
		end
	endfunction

endpackage

// File: src/tcmc_front.sv
// ----------------------------------------------------------------------------
// tcmc_front
// Classifies the colour byte and marks symbols beyond the run length limit.
// ----------------------------------------------------------------------------
module tcmc_front #(
	parameter int MAX_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          symbol,
	input  logic                last,
	input  logic                accept,
	output tcmc_pkg::item_t     item
);
	import tcmc_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);

	logic [CW-1:0] cnt_q;
	logic          full;

	assign full = (cnt_q == CW'(MAX_LEN));

	always_comb begin
		item.obs  = (symbol == SYM_RED)   ? COL_RED :
		            (symbol == SYM_GREEN) ? COL_GREEN : COL_BLUE;
		item.drop = full;
		item.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (last) begin
				cnt_q <= '0;
			end else if (!full) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

// File: src/tcmc_queue.sv
// ----------------------------------------------------------------------------
// tcmc_queue
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
module tcmc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcmc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output tcmc_pkg::item_t pop_item
);
	import tcmc_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int LW = $clog2(QDEPTH + 1);

	item_t         mem_q [QDEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [LW-1:0] level_q;

	assign full      = (level_q == LW'(QDEPTH));
	assign not_empty = (level_q != '0);
	assign pop_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LW'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

endmodule

// File: src/tcmc_back.sv
// ----------------------------------------------------------------------------
// tcmc_back
// Forward cost recurrence, traceback and in-order emission of the path.
// ----------------------------------------------------------------------------
module tcmc_back #(
	parameter int MAX_LEN = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  tcmc_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      color,
	output logic [6:0]      min_changes,
	output logic            end_of_run,
	output logic            overflow
);
	import tcmc_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	typedef enum logic [4:0] {
		ST_FWD   = 5'b00001,
		ST_TBW   = 5'b00010,
		ST_TB    = 5'b00100,
		ST_EMRD  = 5'b01000,
		ST_EMOUT = 5'b10000
	} state_t;

	state_t        state_q;
	logic [6:0]    cost_q [3];
	logic [6:0]    next_cost [3];
	logic [2:0]    bits;
	logic [CW-1:0] cnt_q;
	logic          ovf_seen_q;
	logic [1:0]    cur_q;
	logic [6:0]    best_cost_q;
	logic [AW-1:0] p_q;
	logic [AW-1:0] e_q;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] bc_addr;
	logic [2:0]    bc_mem [MAX_LEN];
	logic [2:0]    bc_rd_q;
	logic [1:0]    path_mem [MAX_LEN];
	logic [1:0]    path_rd_q;
	logic [1:0]    best;
	logic [6:0]    best_c;
	logic [3:0]    cur_oth;
	logic          out_free;
	logic          is_end;
	logic          load;

	assign q_pop    = (state_q == ST_FWD) && q_valid;
	assign last_idx = AW'(cnt_q - CW'(1));
	assign bc_addr  = (state_q == ST_TBW) ? last_idx : p_q - AW'(1);
	assign cur_oth  = others(cur_q);
	assign out_free = !out_valid || !out_stall;
	assign is_end   = (CW'(e_q) + CW'(1) == cnt_q);
	assign load     = (state_q == ST_EMOUT) && out_free;

	always_comb begin
		logic [3:0] o;
		bits = '0;
		for (int c = 0; c < 3; c++) begin
			o = others(2'(c));
			if (cost_q[o[1:0]] < cost_q[o[3:2]]) begin
				next_cost[c] = cost_q[o[1:0]];
			end else begin
				next_cost[c] = cost_q[o[3:2]];
				bits[c] = 1'b1;
			end
			next_cost[c] = next_cost[c] + ((q_item.obs != 2'(c)) ? 7'd1 : 7'd0);
		end
	end

	always_comb begin
		best   = COL_RED;
		best_c = cost_q[0];
		if (cost_q[1] < best_c) begin
			best   = COL_GREEN;
			best_c = cost_q[1];
		end
		if (cost_q[2] < best_c) begin
			best   = COL_BLUE;
			best_c = cost_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !q_item.drop) begin
			bc_mem[cnt_q[AW-1:0]] <= bits;
		end
		bc_rd_q <= bc_mem[bc_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TB) begin
			path_mem[p_q] <= cur_q;
		end
		path_rd_q <= path_mem[e_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FWD;
			cost_q      <= '{default: '0};
			cnt_q       <= '0;
			ovf_seen_q  <= 1'b0;
			cur_q       <= COL_RED;
			best_cost_q <= '0;
			p_q         <= '0;
			e_q         <= '0;
		end else begin
			unique case (state_q)
				ST_FWD: begin
					if (q_valid) begin
						if (!q_item.drop) begin
							cost_q <= next_cost;
							cnt_q  <= cnt_q + CW'(1);
						end else begin
							ovf_seen_q <= 1'b1;
						end
						if (q_item.last) begin
							state_q <= ST_TBW;
						end
					end
				end
				ST_TBW: begin
					cur_q       <= best;
					best_cost_q <= best_c;
					cost_q      <= '{default: '0};
					p_q         <= last_idx;
					state_q     <= ST_TB;
				end
				ST_TB: begin
					cur_q <= bc_rd_q[cur_q] ? cur_oth[3:2] : cur_oth[1:0];
					p_q   <= p_q - AW'(1);
					if (p_q == '0) begin
						e_q     <= '0;
						state_q <= ST_EMRD;
					end
				end
				ST_EMRD: begin
					state_q <= ST_EMOUT;
				end
				ST_EMOUT: begin
					if (out_free) begin
						e_q <= e_q + AW'(1);
						if (is_end) begin
							cnt_q      <= '0;
							ovf_seen_q <= 1'b0;
							state_q    <= ST_FWD;
						end else begin
							state_q <= ST_EMRD;
						end
					end
				end
				default: begin
					state_q <= ST_FWD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			color       <= path_rd_q;
			min_changes <= best_cost_q;
			end_of_run  <= is_end;
			overflow    <= ovf_seen_q;
		end
	end

endmodule

// File: src/three_color_min_change_traceback.sv
// ----------------------------------------------------------------------------
// three_color_min_change_traceback
// Recolours a run of colour symbols with the fewest changes so that no two
// neighbours match, and returns the recoloured run in order.
// ----------------------------------------------------------------------------
// Symbols enter through a two-word queue; the back end folds in one symbol a
// cycle with the three-colour cost update while collecting a run, so a run
// streams in at one word a cycle. No word is emitted until the word marked
// last. The back end then traces back over the n stored positions, one read
// of the choice memory a cycle, and emits each result through a read and an
// output state, as the path memory read is registered; output stall holds
// it. Input words are taken whenever the queue has room, so up to two words
// of the next run wait in the queue while a run is traced back and emitted;
// the back end takes them once the final result is loaded into the output
// register. Symbols beyond MAX_LEN are dropped and flagged as overflow.
module three_color_min_change_traceback #(
	parameter int MAX_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] color,
	output logic [6:0] min_changes,
	output logic       end_of_run,
	output logic       overflow
);
	import tcmc_pkg::*;

	item_t f_item;
	item_t q_item;
	logic  q_full;
	logic  q_valid;
	logic  q_pop;
	logic  push;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	tcmc_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.symbol (symbol),
		.last   (last),
		.accept (push),
		.item   (f_item)
	);

	tcmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (f_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_item  (q_item)
	);

	tcmc_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.color       (color),
		.min_changes (min_changes),
		.end_of_run  (end_of_run),
		.overflow    (overflow)
	);

	a_colour_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (color != 2'd3))
		else $error("colour code out of range");

	a_cost_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_changes <= 7'(MAX_LEN)))
		else $error("change count exceeds run length");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

endmodule
